// ----- sv/sct_pkg.sv -----
package sct_pkg;

  localparam int MaxTokenLen = 255;
  localparam logic [7:0] LenCap = (MaxTokenLen < 255) ? 8'(MaxTokenLen) : 8'd255;

  localparam logic [23:0] OffMax  = 24'hFFFFFF;
  localparam logic [19:0] LineMax = 20'hFFFFF;
  localparam logic [15:0] ColMax  = 16'hFFFF;

  localparam logic [7:0] Bom0 = 8'hEF;
  localparam logic [7:0] Bom1 = 8'hBB;
  localparam logic [7:0] Bom2 = 8'hBF;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_IDENT = 3'd1,
    M_NUM   = 3'd2,
    M_OP    = 3'd3,
    M_LINE  = 3'd4,
    M_BLOCK = 3'd5,
    M_STAR  = 3'd6
  } mode_t;

  localparam logic [5:0] K_ILLEGAL = 6'd0;
  localparam logic [5:0] K_EOF     = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_NUMBER  = 6'd3;
  localparam logic [5:0] K_SHL     = 6'd45;
  localparam logic [5:0] K_SHR     = 6'd49;
  localparam logic [5:0] K_SLASH   = 6'd26;
  localparam logic [5:0] K_DOT2    = 6'd55;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] offset;
    logic [19:0] line;
    logic [15:0] column;
    logic [7:0]  length;
  } token_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0D || c == 8'h09 || c == 8'h0A;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      ";": k = 6'd4;
      ",": k = 6'd5;
      8'h5C: k = 6'd6;
      "[": k = 6'd7;
      "]": k = 6'd8;
      "{": k = 6'd9;
      "}": k = 6'd10;
      "(": k = 6'd11;
      ")": k = 6'd12;
      "?": k = 6'd53;
      "@": k = 6'd59;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] first_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "=": k = 6'd13;
      "+": k = 6'd16;
      "-": k = 6'd19;
      "*": k = 6'd23;
      "/": k = 6'd26;
      "!": k = 6'd28;
      "%": k = 6'd30;
      "&": k = 6'd33;
      "|": k = 6'd37;
      "^": k = 6'd40;
      "<": k = 6'd42;
      ">": k = 6'd47;
      "~": k = 6'd51;
      ".": k = 6'd54;
      ":": k = 6'd57;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] grow_kind(input logic [5:0] k, input logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    case (k)
      6'd13: r = (c == "=") ? 6'd14 : (c == ">") ? 6'd15 : 6'd0;
      6'd16: r = (c == "+") ? 6'd17 : (c == "=") ? 6'd18 : 6'd0;
      6'd19: r = (c == "-") ? 6'd20 : (c == "=") ? 6'd21 : (c == ">") ? 6'd22 : 6'd0;
      6'd23: r = (c == "*") ? 6'd24 : (c == "=") ? 6'd25 : 6'd0;
      6'd26: r = (c == "=") ? 6'd27 : 6'd0;
      6'd28: r = (c == "=") ? 6'd29 : 6'd0;
      6'd30: r = (c == "%") ? 6'd31 : (c == "=") ? 6'd32 : 6'd0;
      6'd33: r = (c == "&") ? 6'd34 : (c == "^") ? 6'd35 : (c == "=") ? 6'd36 : 6'd0;
      6'd37: r = (c == "|") ? 6'd38 : (c == "=") ? 6'd39 : 6'd0;
      6'd40: r = (c == "=") ? 6'd41 : 6'd0;
      6'd42: r = (c == "=") ? 6'd43 : (c == "-") ? 6'd44 : (c == "<") ? 6'd45 : 6'd0;
      6'd45: r = (c == "=") ? 6'd46 : 6'd0;
      6'd47: r = (c == "=") ? 6'd48 : (c == ">") ? 6'd49 : 6'd0;
      6'd49: r = (c == "=") ? 6'd50 : 6'd0;
      6'd51: r = (c == "=") ? 6'd52 : 6'd0;
      6'd54: r = (c == ".") ? 6'd55 : 6'd0;
      6'd55: r = (c == ".") ? 6'd56 : 6'd0;
      6'd57: r = (c == ":") ? 6'd58 : 6'd0;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/sct_outq.sv -----
module sct_outq
  import sct_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  logic   push_two,
  input  token_t push_a,
  input  token_t push_b,
  input  logic   push_last_a,
  output logic   space_ok,
  output logic   out_valid,
  input  logic   out_ready,
  output token_t out_tok,
  output logic   out_last
);

  // Four-entry queue of tokens; accepts up to two per cycle. The space flag
  // asks for room for two more tokens beyond the ones pushed in this cycle.
  token_t     tok_r [4];
  logic [3:0] last_r;
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [2:0] n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_tok   = tok_r[rd_r];
  assign out_last  = last_r[rd_r];
  assign space_ok  = (cnt_r + n_push) <= 3'd2;
  assign n_push    = push_valid ? (push_two ? 3'd2 : 3'd1) : 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 2'd0;
      wr_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push_valid) begin
        tok_r[wr_r]  <= push_a;
        last_r[wr_r] <= push_last_a;
        if (push_two) begin
          tok_r[wr_r + 2'd1]  <= push_b;
          last_r[wr_r + 2'd1] <= 1'b1;
        end
        wr_r <= wr_r + n_push[1:0];
      end
      if (pop) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + n_push - {2'b00, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("token queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> cnt_r <= 3'd2) else $error("push without room");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!push_valid && pop) |=> cnt_r == $past(cnt_r) - 3'd1) else $error("bad pop count");
`endif

endmodule

// ----- sv/source_code_tokenizer_top.sv -----
// Channel | Ports                                      | Direction
// input   | in_valid in_ready in_action in_source_byte | into block
// result  | out_valid out_ready out_token_kind ...     | out of block
// One input transaction per cycle; each causes zero, one or two tokens.
// Input is registered, decoded in the next cycle, and tokens enter a four-entry
// queue, from which the result channel reads them in order.
// in_ready drops while the queue, counting the tokens now being decoded, has
// no room for two more.
// Synchronous active-low reset returns the scanner to the start of a text.
module source_code_tokenizer_top
  import sct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [23:0] out_start_offset,
  output logic [19:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [7:0]  out_token_length,
  output logic        out_last_of_run
);

  logic        iv_r;
  logic        act_r;
  logic [7:0]  c_r;

  mode_t       mode_r, mode_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic [23:0] ts_off_r, ts_off_nxt, off_r, off_nxt;
  logic [19:0] ts_line_r, ts_line_nxt, line_r, line_nxt;
  logic [15:0] ts_col_r, ts_col_nxt, col_r, col_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [1:0]  bom_r, bom_nxt;

  logic        space_ok;
  token_t      tk_a, tk_b, out_tok;
  logic [1:0]  n_tok;
  logic        emit_valid;

  assign in_ready = space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= in_valid && in_ready;
    end
    if (in_valid && in_ready) begin
      act_r <= in_action;
      c_r   <= in_source_byte;
    end
  end

  always_comb begin
    logic [7:0]  bl;
    logic [7:0]  bm;
    logic [5:0]  sk, fk, gk;
    logic        do_idle;
    token_t      t;
    n_tok       = 2'd0;
    tk_a        = '0;
    tk_b        = '0;
    mode_nxt    = mode_r;
    pend_nxt    = pend_r;
    ts_off_nxt  = ts_off_r;
    ts_line_nxt = ts_line_r;
    ts_col_nxt  = ts_col_r;
    cnt_nxt     = cnt_r;
    off_nxt     = off_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    bom_nxt     = bom_r;
    do_idle     = 1'b0;
    t           = '0;
    sk = single_kind(c_r);
    fk = first_kind(c_r);
    gk = grow_kind(pend_r, c_r);
    case (bom_r)
      2'd0: bm = Bom0;
      2'd1: bm = Bom1;
      default: bm = Bom2;
    endcase
    bl = {6'd0, bom_r};

    if (act_r) begin
      if (bom_r == 2'd1 || bom_r == 2'd2) begin
        tk_a = '{K_ILLEGAL, 24'd0, 20'd1, 16'd1, bl};
        n_tok = 2'd1;
        col_nxt = 16'd1 + {14'd0, bom_r};
      end
      if (mode_r == M_IDENT || mode_r == M_NUM || mode_r == M_OP) begin
        t.kind = (mode_r == M_IDENT) ? K_IDENT : (mode_r == M_NUM) ? K_NUMBER : pend_r;
        t.offset = ts_off_r; t.line = ts_line_r; t.column = ts_col_r; t.length = cnt_r;
        if (n_tok == 2'd0) tk_a = t; else tk_b = t;
        n_tok = n_tok + 2'd1;
      end
      t = '{K_EOF, off_r, line_r, col_nxt, 8'd0};
      if (n_tok == 2'd0) tk_a = t; else tk_b = t;
      n_tok = n_tok + 2'd1;
      mode_nxt = M_IDLE; pend_nxt = 6'd0;
      ts_off_nxt = 24'd0; ts_line_nxt = 20'd1; ts_col_nxt = 16'd1; cnt_nxt = 8'd0;
      off_nxt = 24'd0; line_nxt = 20'd1; col_nxt = 16'd1; bom_nxt = 2'd0;
    end else if (bom_r != 2'd3 && c_r == bm) begin
      bom_nxt = bom_r + 2'd1;
      if (off_r < OffMax) off_nxt = off_r + 24'd1;
    end else begin
      if (bom_r == 2'd1 || bom_r == 2'd2) begin
        tk_a = '{K_ILLEGAL, 24'd0, 20'd1, 16'd1, bl};
        n_tok = 2'd1;
        col_nxt = 16'd1 + {14'd0, bom_r};
      end
      bom_nxt = 2'd3;
      t = '{(mode_r == M_IDENT) ? K_IDENT : (mode_r == M_NUM) ? K_NUMBER : pend_r,
            ts_off_r, ts_line_r, ts_col_r, cnt_r};
      case (mode_r)
        M_IDENT: begin
          if (is_alpha(c_r) || is_digit(c_r)) begin
            if (cnt_r < LenCap) cnt_nxt = cnt_r + 8'd1;
          end else do_idle = 1'b1;
        end
        M_NUM: begin
          if (is_digit(c_r)) begin
            if (cnt_r < LenCap) cnt_nxt = cnt_r + 8'd1;
          end else do_idle = 1'b1;
        end
        M_OP: begin
          if (pend_r == K_SLASH && c_r == "/") begin
            mode_nxt = M_LINE; pend_nxt = 6'd0;
          end else if (pend_r == K_SLASH && c_r == "*") begin
            mode_nxt = M_BLOCK; pend_nxt = 6'd0;
          end else if (gk != 6'd0) begin
            pend_nxt = gk;
            cnt_nxt = (cnt_r < LenCap) ? cnt_r + 8'd1 : cnt_r;
            if (gk != K_SHL && gk != K_SHR && gk != K_DOT2) begin
              t.kind = gk; t.length = cnt_nxt;
              if (n_tok == 2'd0) tk_a = t; else tk_b = t;
              n_tok = n_tok + 2'd1;
              mode_nxt = M_IDLE; pend_nxt = 6'd0;
            end
          end else do_idle = 1'b1;
        end
        M_LINE:  if (c_r == 8'h0A) mode_nxt = M_IDLE;
        M_BLOCK: if (c_r == "*") mode_nxt = M_STAR;
        M_STAR: begin
          if (c_r == "/") mode_nxt = M_IDLE;
          else if (c_r != "*") mode_nxt = M_BLOCK;
        end
        default: begin
          mode_nxt = M_IDLE;
          t = '{K_ILLEGAL, off_r, line_r, col_nxt, 8'd1};
          if (is_space(c_r)) begin
          end else if (is_alpha(c_r) || is_digit(c_r) || fk != 6'd0) begin
            mode_nxt = is_alpha(c_r) ? M_IDENT : is_digit(c_r) ? M_NUM : M_OP;
            if (fk != 6'd0 && !is_alpha(c_r) && !is_digit(c_r)) pend_nxt = fk;
            ts_off_nxt = off_r; ts_line_nxt = line_r; ts_col_nxt = col_nxt;
            cnt_nxt = 8'd1;
          end else begin
            t.kind = sk;
            if (n_tok == 2'd0) tk_a = t; else tk_b = t;
            n_tok = n_tok + 2'd1;
          end
        end
      endcase
      if (do_idle) begin
        tk_a = t;
        n_tok = 2'd1;
        pend_nxt = 6'd0;
        mode_nxt = M_IDLE;
        t = '{K_ILLEGAL, off_r, line_r, col_nxt, 8'd1};
        if (is_space(c_r)) begin
        end else if (is_alpha(c_r) || is_digit(c_r) || fk != 6'd0) begin
          mode_nxt = is_alpha(c_r) ? M_IDENT : is_digit(c_r) ? M_NUM : M_OP;
          if (fk != 6'd0 && !is_alpha(c_r) && !is_digit(c_r)) pend_nxt = fk;
          ts_off_nxt = off_r; ts_line_nxt = line_r; ts_col_nxt = col_nxt;
          cnt_nxt = 8'd1;
        end else begin
          t.kind = sk;
          tk_b = t;
          n_tok = 2'd2;
        end
      end
      if (off_r < OffMax) off_nxt = off_r + 24'd1;
      if (c_r == 8'h0A) begin
        if (line_r < LineMax) line_nxt = line_r + 20'd1;
        col_nxt = 16'd1;
      end else if (col_nxt < ColMax) begin
        col_nxt = col_nxt + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      pend_r    <= 6'd0;
      ts_off_r  <= 24'd0;
      ts_line_r <= 20'd1;
      ts_col_r  <= 16'd1;
      cnt_r     <= 8'd0;
      off_r     <= 24'd0;
      line_r    <= 20'd1;
      col_r     <= 16'd1;
      bom_r     <= 2'd0;
    end else if (iv_r) begin
      mode_r    <= mode_nxt;
      pend_r    <= pend_nxt;
      ts_off_r  <= ts_off_nxt;
      ts_line_r <= ts_line_nxt;
      ts_col_r  <= ts_col_nxt;
      cnt_r     <= cnt_nxt;
      off_r     <= off_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      bom_r     <= bom_nxt;
    end
  end

  assign emit_valid = iv_r && (n_tok != 2'd0);

  sct_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (emit_valid),
    .push_two   (n_tok == 2'd2),
    .push_a     (tk_a),
    .push_b     (tk_b),
    .push_last_a(n_tok == 2'd1),
    .space_ok   (space_ok),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_tok    (out_tok),
    .out_last   (out_last_of_run)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_start_offset = out_tok.offset;
  assign out_start_line   = out_tok.line;
  assign out_start_column = out_tok.column;
  assign out_token_length = out_tok.length;

`ifndef ASSERT_OFF
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && act_r) |-> n_tok != 2'd0) else $error("end of text without eof");
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != 3'd7) else $error("unreachable mode");
  a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && act_r) |=> off_r == 24'd0 && bom_r == 2'd0) else $error("eof did not reset");
  a_op_pending: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_OP |-> pend_r != 6'd0) else $error("operator mode without operator");
`endif

endmodule
